@@ rtl/dti_pkg.sv @@
`timescale 1ns / 1ps
package dti_pkg;

  // Fixed field widths of the request and response items.
  localparam int unsigned KEY_FIELD_W = 48;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned COUNT_W     = 9;
  localparam int unsigned INDEX_W     = 8;

  // Command codes.
  localparam logic [0:0] CMD_LOAD  = 1'b0;
  localparam logic [0:0] CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [0:0]             cmd;
    logic [INDEX_W-1:0]     entry_index;
    logic [KEY_FIELD_W-1:0] key;
    logic [VAL_W-1:0]       energy_value;
    logic [VAL_W-1:0]       entropy_value;
  } req_t;

  typedef struct packed {
    logic [VAL_W-1:0] energy_out;
    logic [VAL_W-1:0] entropy_out;
    logic             below_range;
    logic             above_range;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ_FIRST,
    ST_READ_LAST,
    ST_SCAN,
    ST_DIVIDE,
    ST_DONE
  } state_t;

endpackage

@@ rtl/dti_ram.sv @@
`timescale 1ns / 1ps
module dti_ram #(
  parameter int unsigned WIDTH = 112,
  parameter int unsigned DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ rtl/dof_table_interpolator_core.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// req       in         req_valid/req_stall  dti_pkg::req_t (load or query)
// rsp       out        rsp_valid/rsp_stall  dti_pkg::rsp_t (one per query)
// cfg       in         entry_count_we       entry_count_wdata (9 bits)
//
// A load item is written to the table RAM at the edge that accepts it, and the request
// side stays ready. A query item reads the first breakpoint at the accepting edge and
// the last one in the cycle after, then walks the table one entry per cycle (one read
// per cycle on the single read port) until it finds the bracketing breakpoint, then runs
// a 32-step radix-2 multiply-divide. The scan and the divide are skipped for a key outside
// the table or equal to the first breakpoint. The request side stalls from the accepting
// edge until the query ends; the response turns valid at the edge that ends the stall.
// Reset (rst, synchronous) clears the control state and sets entry_count to 2; the table
// contents are undefined until loaded. A stalled response holds; a new item is accepted
// while a response still waits, and the next query then waits in its last cycle until
// that response leaves.
module dof_table_interpolator_core #(
  parameter int unsigned TABLE_DEPTH = 256,
  parameter int unsigned KEY_WIDTH   = 48
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  dti_pkg::req_t                     req,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output dti_pkg::rsp_t                     rsp,
  input  logic                              entry_count_we,
  input  logic [dti_pkg::COUNT_W-1:0]       entry_count_wdata
);
  import dti_pkg::*;

  localparam int unsigned AW  = $clog2(TABLE_DEPTH);
  localparam int unsigned CW  = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned NW  = (CW > COUNT_W) ? CW : COUNT_W;
  localparam int unsigned IW  = (NW > INDEX_W) ? NW : INDEX_W;
  localparam int unsigned RW  = KEY_WIDTH + 2 * VAL_W;
  localparam int unsigned BW  = $clog2(VAL_W);

  state_t state, state_next;

  logic [COUNT_W-1:0]   entry_count;
  logic [NW-1:0]        count_ext;
  logic [NW-1:0]        count_eff;
  logic [AW-1:0]        last_idx;

  // Table RAM: each word packs key, energy and entropy.
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RW-1:0]        ram_wdata;
  logic [AW-1:0]        ram_raddr;
  logic [RW-1:0]        ram_rdata;
  logic [KEY_WIDTH-1:0] rd_key;
  logic [VAL_W-1:0]     rd_e;
  logic [VAL_W-1:0]     rd_s;

  logic                 req_accept;
  logic [KEY_WIDTH-1:0] req_key;

  // Query working registers.
  logic [KEY_WIDTH-1:0] key_q;
  logic [KEY_WIDTH-1:0] prev_k;
  logic [VAL_W-1:0]     prev_e;
  logic [VAL_W-1:0]     prev_s;
  logic [AW-1:0]        idx;
  logic                 found;

  // Multiply-divide unit: q = floor(a * b / d), one bit of a per cycle, shared b and d.
  logic [KEY_WIDTH-1:0] div_b;
  logic [KEY_WIDTH-1:0] div_d;
  logic [VAL_W-1:0]     a_e, a_s;
  logic [KEY_WIDTH-1:0] r_e, r_s;
  logic [VAL_W-1:0]     q_e, q_s;
  logic [VAL_W-1:0]     base_e, base_s;
  logic                 neg_e, neg_s;
  logic [BW-1:0]        bit_cnt;
  logic                 below, above;
  logic [KEY_WIDTH+1:0] step_e, step_s;

  logic                 slot_free;

  // One radix-2 step. The partial remainder stays below d, so 2r + b stays below 3d
  // and the quotient digit is 0, 1 or 2. Returns {digit, new remainder}.
  function automatic logic [KEY_WIDTH+1:0] div_step(
    input logic [KEY_WIDTH-1:0] r,
    input logic                 abit,
    input logic [KEY_WIDTH-1:0] b,
    input logic [KEY_WIDTH-1:0] d
  );
    logic [KEY_WIDTH+1:0] t;
    logic [KEY_WIDTH+1:0] d1;
    logic [KEY_WIDTH+1:0] d2;
    t  = {1'b0, r, 1'b0} + (abit ? {2'b00, b} : '0);
    d1 = {2'b00, d};
    d2 = {1'b0, d, 1'b0};
    if (t >= d2) begin
      t = t - d2;
      div_step = {2'd2, t[KEY_WIDTH-1:0]};
    end else if (t >= d1) begin
      t = t - d1;
      div_step = {2'd1, t[KEY_WIDTH-1:0]};
    end else begin
      div_step = {2'd0, t[KEY_WIDTH-1:0]};
    end
  endfunction

  assign req_key    = KEY_WIDTH'(req.key);
  assign req_stall  = (state != ST_IDLE);
  assign req_accept = req_valid && !req_stall;
  assign slot_free  = !rsp_valid || !rsp_stall;

  // Effective entry count, held between 2 and TABLE_DEPTH.
  assign count_ext = NW'(entry_count);
  always_comb begin
    if (count_ext < NW'(2)) begin
      count_eff = NW'(2);
    end else if (count_ext > NW'(TABLE_DEPTH)) begin
      count_eff = NW'(TABLE_DEPTH);
    end else begin
      count_eff = count_ext;
    end
  end
  assign last_idx = AW'(count_eff - NW'(1));

  assign ram_we    = req_accept && (req.cmd == CMD_LOAD) &&
                     (IW'(req.entry_index) < IW'(TABLE_DEPTH));
  assign ram_waddr = AW'(req.entry_index);
  assign ram_wdata = {req_key, req.energy_value, req.entropy_value};
  assign rd_key    = ram_rdata[RW-1 -: KEY_WIDTH];
  assign rd_e      = ram_rdata[2*VAL_W-1 -: VAL_W];
  assign rd_s      = ram_rdata[VAL_W-1:0];

  assign found  = (idx == last_idx) || (rd_key >= key_q);
  assign step_e = div_step(r_e, a_e[VAL_W-1], div_b, div_d);
  assign step_s = div_step(r_s, a_s[VAL_W-1], div_b, div_d);

  dti_ram #(
    .WIDTH(RW),
    .DEPTH(TABLE_DEPTH)
  ) u_table (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // Next state and the RAM read address.
  always_comb begin
    state_next = state;
    ram_raddr  = '0;
    unique case (state)
      ST_IDLE: begin
        if (req_accept && (req.cmd == CMD_QUERY)) begin
          state_next = ST_READ_FIRST;
        end
      end
      ST_READ_FIRST: begin
        ram_raddr  = last_idx;
        state_next = ST_READ_LAST;
      end
      ST_READ_LAST: begin
        if ((key_q < prev_k) || (key_q > rd_key) || (prev_k >= key_q)) begin
          state_next = ST_DONE;
        end else begin
          ram_raddr  = AW'(1);
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (found) begin
          state_next = ST_DIVIDE;
        end else begin
          ram_raddr = idx + AW'(1);
        end
      end
      ST_DIVIDE: begin
        if (bit_cnt == '0) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (slot_free) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= COUNT_W'(2);
    end else if (entry_count_we) begin
      entry_count <= entry_count_wdata;
    end
  end

  // Query datapath.
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (req_accept) begin
          key_q <= req_key;
        end
      end
      ST_READ_FIRST: begin
        prev_k <= rd_key;
        prev_e <= rd_e;
        prev_s <= rd_s;
      end
      ST_READ_LAST: begin
        below  <= 1'b0;
        above  <= 1'b0;
        q_e    <= '0;
        q_s    <= '0;
        neg_e  <= 1'b0;
        neg_s  <= 1'b0;
        idx    <= AW'(1);
        if (key_q < prev_k) begin
          base_e <= prev_e;
          base_s <= prev_s;
          below  <= 1'b1;
        end else if (key_q > rd_key) begin
          base_e <= rd_e;
          base_s <= rd_s;
          above  <= 1'b1;
        end else begin
          // A key equal to the first breakpoint takes the first values.
          base_e <= prev_e;
          base_s <= prev_s;
        end
      end
      ST_SCAN: begin
        if (found) begin
          div_b   <= key_q - prev_k;
          div_d   <= rd_key - prev_k;
          base_e  <= prev_e;
          base_s  <= prev_s;
          neg_e   <= rd_e < prev_e;
          neg_s   <= rd_s < prev_s;
          a_e     <= (rd_e < prev_e) ? prev_e - rd_e : rd_e - prev_e;
          a_s     <= (rd_s < prev_s) ? prev_s - rd_s : rd_s - prev_s;
          r_e     <= '0;
          r_s     <= '0;
          q_e     <= '0;
          q_s     <= '0;
          bit_cnt <= BW'(VAL_W - 1);
        end else begin
          prev_k <= rd_key;
          prev_e <= rd_e;
          prev_s <= rd_s;
          idx    <= idx + AW'(1);
        end
      end
      ST_DIVIDE: begin
        a_e     <= a_e << 1;
        a_s     <= a_s << 1;
        r_e     <= step_e[KEY_WIDTH-1:0];
        r_s     <= step_s[KEY_WIDTH-1:0];
        q_e     <= {q_e[VAL_W-2:0], 1'b0} + VAL_W'(step_e[KEY_WIDTH+1:KEY_WIDTH]);
        q_s     <= {q_s[VAL_W-2:0], 1'b0} + VAL_W'(step_s[KEY_WIDTH+1:KEY_WIDTH]);
        bit_cnt <= bit_cnt - BW'(1);
      end
      ST_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if ((state == ST_DONE) && slot_free) begin
      rsp_valid <= 1'b1;
    end else if (rsp_valid && !rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_DONE) && slot_free) begin
      rsp.energy_out  <= neg_e ? base_e - q_e : base_e + q_e;
      rsp.entropy_out <= neg_s ? base_s - q_s : base_s + q_s;
      rsp.below_range <= below;
      rsp.above_range <= above;
    end
  end

endmodule

@@ rtl/dti_checker.sv @@
`timescale 1ns / 1ps
module dti_checker (
  input logic          clk,
  input logic          rst,
  input logic          req_valid,
  input logic          req_stall,
  input dti_pkg::req_t req,
  input logic          rsp_valid,
  input logic          rsp_stall,
  input dti_pkg::rsp_t rsp
);
  import dti_pkg::*;

  // A response held by stall stays offered.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  a_rsp_stable: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> $stable(rsp))
    else $error("response changed while stalled");

  // An accepted query keeps the request side busy in the next cycle.
  a_query_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall && (req.cmd == CMD_QUERY) |=> req_stall)
    else $error("request taken during a query");

  // A key cannot lie both below and above the table.
  a_range_excl: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp.below_range && rsp.above_range))
    else $error("both range flags set");

endmodule

bind dof_table_interpolator_core dti_checker u_dti_checker (
  .clk      (clk),
  .rst      (rst),
  .req_valid(req_valid),
  .req_stall(req_stall),
  .req      (req),
  .rsp_valid(rsp_valid),
  .rsp_stall(rsp_stall),
  .rsp      (rsp)
);

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import dti_pkg::*;

  // The table interpolator is checked against a predictor that keeps its own copy of the
  // breakpoint table and the entry count. Every accepted item goes to the scoreboard. A
  // load updates the predicted table, and a query pushes the expected response. Every
  // accepted response is compared with the oldest expected one.

  class dof_scoreboard;
    logic [KEY_FIELD_W-1:0] keys[256];
    logic [VAL_W-1:0]       energy[256];
    logic [VAL_W-1:0]       entropy[256];
    logic [COUNT_W-1:0]     count_reg;
    rsp_t                   expected_rsp[$];
    int                     errors;

    function new();
      count_reg = 9'd2;
      errors = 0;
    endfunction

    task report(string what);
      $display("mismatch at %0t: %s", $realtime, what);
      errors++;
    endtask

    // The block clamps the count to the range 2 to 256.
    function int active_count();
      if (count_reg < 2) return 2;
      if (count_reg > 256) return 256;
      return int'(count_reg);
    endfunction

    // The product is formed exactly before the truncating division.
    function logic [VAL_W-1:0] blend(logic [VAL_W-1:0] v_lo, logic [VAL_W-1:0] v_hi,
                                     logic [KEY_FIELD_W-1:0] off,
                                     logic [KEY_FIELD_W-1:0] span);
      logic [127:0] prod;
      logic [127:0] quot;
      logic [VAL_W-1:0] diff;
      diff = (v_hi >= v_lo) ? v_hi - v_lo : v_lo - v_hi;
      prod = {96'b0, diff} * {80'b0, off};
      quot = prod / {80'b0, span};
      return (v_hi >= v_lo) ? v_lo + quot[VAL_W-1:0] : v_lo - quot[VAL_W-1:0];
    endfunction

    function void note_input(req_t r);
      rsp_t p;
      int n;
      int i;
      if (r.cmd == CMD_LOAD) begin
        keys[r.entry_index] = r.key;
        energy[r.entry_index] = r.energy_value;
        entropy[r.entry_index] = r.entropy_value;
        return;
      end
      n = active_count();
      p = '0;
      if (r.key < keys[0]) begin
        p.energy_out = energy[0];
        p.entropy_out = entropy[0];
        p.below_range = 1'b1;
      end else if (r.key > keys[n-1]) begin
        p.energy_out = energy[n-1];
        p.entropy_out = entropy[n-1];
        p.above_range = 1'b1;
      end else begin
        i = 0;
        while (i < n - 1 && keys[i] < r.key) i++;
        if (i == 0) begin
          p.energy_out = energy[0];
          p.entropy_out = entropy[0];
        end else begin
          p.energy_out = blend(energy[i-1], energy[i], r.key - keys[i-1],
                               keys[i] - keys[i-1]);
          p.entropy_out = blend(entropy[i-1], entropy[i], r.key - keys[i-1],
                                keys[i] - keys[i-1]);
        end
      end
      expected_rsp = {expected_rsp, p};
    endfunction

    task check_result(rsp_t got);
      rsp_t want;
      if (expected_rsp.size() == 0) begin
        report("response with no query waiting");
        return;
      end
      want = expected_rsp.pop_front();
      if (got.energy_out !== want.energy_out)
        report($sformatf("energy_out %h, want %h", got.energy_out, want.energy_out));
      if (got.entropy_out !== want.entropy_out)
        report($sformatf("entropy_out %h, want %h", got.entropy_out, want.entropy_out));
      if (got.below_range !== want.below_range)
        report($sformatf("below_range %b, want %b", got.below_range, want.below_range));
      if (got.above_range !== want.above_range)
        report($sformatf("above_range %b, want %b", got.above_range, want.above_range));
    endtask
  endclass

  logic clk;
  logic rst;
  logic req_valid;
  logic req_stall;
  req_t req;
  logic rsp_valid;
  logic rsp_stall;
  rsp_t rsp;
  logic entry_count_we;
  logic [COUNT_W-1:0] entry_count_wdata;

  dof_scoreboard sb;
  bit quiet;
  int sent;
  int stall_left;
  // Sorted keys of the table currently loaded for a phase.
  logic [KEY_FIELD_W-1:0] phase_keys[256];

  dof_table_interpolator_core u_dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .entry_count_we(entry_count_we),
    .entry_count_wdata(entry_count_wdata)
  );

  always begin
    clk = 1'b1;
    #1;
    clk = 1'b0;
    #1;
  end

  // Both sides are sampled at the edge, before any of this step's updates land.
  always @(posedge clk) begin
    if (!rst && req_valid && !req_stall) sb.note_input(req);
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp);
  end

  // The response side stalls in random bursts, except in the quiet tail of the run.
  always @(posedge clk) begin
    if (rst) begin
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else if (!quiet && $urandom_range(0, 7) == 0) begin
      stall_left = $urandom_range(1, 14);
    end
    rsp_stall <= (stall_left > 0);
  end

  // Called at a rising edge; returns at the edge that accepts the item.
  task send(req_t r);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= r;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sent++;
  endtask

  task send_load(int idx, logic [KEY_FIELD_W-1:0] k, logic [VAL_W-1:0] e,
                 logic [VAL_W-1:0] s);
    req_t r;
    r.cmd = CMD_LOAD;
    r.entry_index = idx[INDEX_W-1:0];
    r.key = k;
    r.energy_value = e;
    r.entropy_value = s;
    send(r);
  endtask

  task send_query(logic [KEY_FIELD_W-1:0] k);
    req_t r;
    r.cmd = CMD_QUERY;
    r.entry_index = INDEX_W'($urandom);
    r.key = k;
    r.energy_value = $urandom;
    r.entropy_value = $urandom;
    send(r);
  endtask

  // Wait until every expected response is in, then for the longest query the block
  // could still be working on.
  task drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_rsp.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);
  endtask

  task write_count(logic [COUNT_W-1:0] v);
    drain();
    entry_count_we <= 1'b1;
    entry_count_wdata <= v;
    @(posedge clk);
    sb.count_reg = v;
    entry_count_we <= 1'b0;
    entry_count_wdata <= COUNT_W'($urandom);
    @(posedge clk);
  endtask

  function logic [KEY_FIELD_W-1:0] rand_key();
    return KEY_FIELD_W'({$urandom, $urandom});
  endfunction

  // Loads a sorted table over the active entries, then mixes queries that hit every
  // region with a little noise: stray loads and keys drawn from the whole range.
  task run_phase(logic [COUNT_W-1:0] count_val, int items);
    int n;
    int j;
    int pick;
    logic [KEY_FIELD_W-1:0] k;
    logic [KEY_FIELD_W-1:0] gap;
    write_count(count_val);
    n = sb.active_count();
    k = rand_key() >> $urandom_range(2, 40);
    for (j = 0; j < n; j++) begin
      phase_keys[j] = k;
      send_load(j, k, $urandom, $urandom);
      gap = rand_key() >> ($urandom_range(9, 47));
      if ($urandom_range(0, 15) == 0) gap = 0;
      k = k + gap;
    end
    for (j = 0; j < items; j++) begin
      pick = $urandom_range(0, 15);
      if (pick == 0) begin
        send_load($urandom_range(0, 255), rand_key(), $urandom, $urandom);
      end else if (pick == 1) begin
        send_query(rand_key());
      end else if (pick == 2) begin
        send_query(phase_keys[0] - $urandom_range(0, 3));
      end else if (pick == 3) begin
        send_query(phase_keys[n-1] + $urandom_range(0, 3));
      end else if (pick <= 6) begin
        send_query(phase_keys[$urandom_range(0, n - 1)]);
      end else begin
        pick = $urandom_range(0, n - 2);
        gap = phase_keys[pick+1] - phase_keys[pick];
        send_query(phase_keys[pick] + (gap == 0 ? '0 : rand_key() % gap));
      end
    end
  endtask

  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  initial begin
    int j;
    sb = new();
    quiet = 1'b0;
    sent = 0;
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    entry_count_we = 1'b0;
    entry_count_wdata = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Two entries with falling energy and rising entropy: below, equal to the first,
    // between, equal to the last, above, and the key extremes.
    send_load(0, 48'h100, 32'hFFFF_FFFF, 32'h0);
    send_load(1, 48'h1_0000_0000, 32'h0, 32'hFFFF_FFFF);
    send_query(48'h0);
    send_query(48'hFF);
    send_query(48'h100);
    send_query(48'h101);
    send_query(48'h8000_0000);
    send_query(48'hFFFF_FFFF);
    send_query(48'h1_0000_0000);
    send_query(48'hFFFF_FFFF_FFFF);
    // Widest span in the key field.
    send_load(0, 48'h0, 32'h0, 32'hFFFF_FFFF);
    send_load(1, 48'hFFFF_FFFF_FFFF, 32'hFFFF_FFFF, 32'h0);
    send_query(48'h0);
    send_query(48'h1);
    send_query(48'h7FFF_FFFF_FFFF);
    send_query(48'hFFFF_FFFF_FFFE);
    send_query(48'hFFFF_FFFF_FFFF);
    // Duplicate breakpoints: an equal key takes the first entry.
    send_load(0, 48'h5, 32'h1234_5678, 32'h9ABC_DEF0);
    send_load(1, 48'h5, 32'h0F0F_0F0F, 32'hF0F0_F0F0);
    send_query(48'h4);
    send_query(48'h5);
    send_query(48'h6);

    // Entries 2 to 255 are written here, so no query ever reads an unwritten one.
    for (j = 2; j < 256; j++) send_load(j, rand_key(), $urandom, $urandom);

    run_phase(9'd256, 80);
    run_phase(9'd0, 60);
    run_phase(9'd1, 40);
    run_phase(9'd511, 60);
    run_phase(9'd3, 80);
    // The sender holds off here until the block has answered everything.
    drain();
    run_phase(9'd2, 60);
    while (sent < 1100) run_phase(9'($urandom_range(2, 24)), 60);
    quiet = 1'b1;
    run_phase(9'($urandom_range(4, 40)), 60);

    drain();
    if (sb.errors == 0 && sb.expected_rsp.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (sb.expected_rsp.size() != 0) sb.report("responses never arrived");
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
